>>> rtl/esp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esp_pkg: shared types and constants of the escaped string printer
// Field widths, mode and register codes, character constants and the
// structs that travel between the render logic and the top level.
// ----------------------------------------------------------------------------
package esp_pkg;

    // Field and register widths.
    localparam int MODE_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int MAX_WIDTH_W = 17;
    localparam int USED_W      = 18;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = MAX_WIDTH_W;

    // Buffer room for one item: opening quote, escape, closing quote
    // and the truncation mark, though one item never holds all four.
    localparam int CHARS_MAX = 11;
    localparam int COUNT_W   = $clog2(CHARS_MAX + 1);
    localparam int POS_W     = $clog2(CHARS_MAX);

    // Register reset values.
    localparam logic [MAX_WIDTH_W-1:0] MAX_WIDTH_RESET    = MAX_WIDTH_W'(40);
    localparam logic                   QUOTE_ENABLE_RESET = 1'b1;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_WIDTH    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_QUOTE_ENABLE = CFG_INDEX_W'(1);

    // Input modes; the fourth code is reserved and ignored.
    localparam logic [MODE_W-1:0] MODE_DATA  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EMPTY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NULL  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;

    // Characters.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_L      = 8'h6C;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data_byte;
        logic              is_final;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       text_end;
    } out_item_t;

    // Per-string state carried from item to item.
    typedef struct packed {
        logic [USED_W-1:0] used_width;
        logic              started;
        logic              dropping;
    } str_state_t;

    // Rendered characters of one item.
    typedef struct packed {
        logic [CHARS_MAX-1:0][7:0] chars;
        logic [COUNT_W-1:0]        count;
        logic                      ends;
    } render_t;

endpackage

>>> rtl/esp_render.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esp_render: renders one input item into its output characters
// Pure combinational logic: from the string state, the registers and one
// item it gives the character list, its length and the next string state.
// ----------------------------------------------------------------------------
module esp_render
(
    input  esp_pkg::str_state_t              state,
    input  esp_pkg::in_item_t                item,
    input  logic [esp_pkg::MAX_WIDTH_W-1:0]  max_width,
    input  logic                             quote_enable,
    output esp_pkg::render_t                 result,
    output esp_pkg::str_state_t              state_next
);

    logic [esp_pkg::USED_W-1:0] limit;
    logic [esp_pkg::USED_W:0]   sum;
    logic [esp_pkg::USED_W-1:0] width_new;
    logic                       plain;
    logic [esp_pkg::BYTE_W-1:0] b;

    assign limit = {1'b0, max_width};
    assign b     = item.data_byte;
    assign plain = ((b >= 8'h20) && (b <= 8'h7E)) || ((b >= 8'h09) && (b <= 8'h0D));

    // Saturating count after this byte.
    always_comb
    begin
        sum = {1'b0, state.used_width} + (plain ? 19'd1 : 19'd3);
        width_new = sum[esp_pkg::USED_W] ? {esp_pkg::USED_W{1'b1}}
                                         : sum[esp_pkg::USED_W-1:0];
    end

    // Character list and state update, appended one character at a time.
    always_comb
    begin
        logic [esp_pkg::COUNT_W-1:0] pos;
        logic                        trunc;
        pos          = '0;
        trunc        = 1'b0;
        result.chars = '0;
        result.ends  = 1'b0;
        state_next   = state;
        unique case (item.mode)
            esp_pkg::MODE_EMPTY:
            begin
                state_next = '0;
                result.ends = 1'b1;
                if (quote_enable)
                begin
                    result.chars[0] = esp_pkg::CH_QUOTE;
                    result.chars[1] = esp_pkg::CH_QUOTE;
                    pos = esp_pkg::COUNT_W'(2);
                end
            end
            esp_pkg::MODE_NULL:
            begin
                state_next = '0;
                result.ends = 1'b1;
                result.chars[0] = esp_pkg::CH_LPAREN;
                result.chars[1] = esp_pkg::CH_N;
                result.chars[2] = esp_pkg::CH_U;
                result.chars[3] = esp_pkg::CH_L;
                result.chars[4] = esp_pkg::CH_L;
                result.chars[5] = esp_pkg::CH_RPAREN;
                pos = esp_pkg::COUNT_W'(6);
            end
            esp_pkg::MODE_RSVD:
            begin
                state_next = state;
            end
            esp_pkg::MODE_DATA:
            begin
                if (state.dropping)
                begin
                    // Remaining bytes of a truncated string are dropped.
                    if (item.is_final)
                    begin
                        state_next = '0;
                    end
                end
                else
                begin
                    state_next.started = 1'b1;
                    if (!state.started && quote_enable)
                    begin
                        result.chars[pos[esp_pkg::POS_W-1:0]] = esp_pkg::CH_QUOTE;
                        pos = pos + 1'b1;
                    end
                    if (state.used_width >= limit)
                    begin
                        // Limit already reached: this byte is not shown.
                        trunc = 1'b1;
                        result.ends = 1'b1;
                        if (item.is_final)
                        begin
                            state_next = '0;
                        end
                        else
                        begin
                            state_next.dropping = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next.used_width = width_new;
                        if (plain)
                        begin
                            result.chars[pos[esp_pkg::POS_W-1:0]] = b;
                            pos = pos + 1'b1;
                        end
                        else if (width_new < limit)
                        begin
                            result.chars[pos[esp_pkg::POS_W-1:0]] = esp_pkg::CH_BSLASH;
                            pos = pos + 1'b1;
                            result.chars[pos[esp_pkg::POS_W-1:0]] = {6'b001100, b[7:6]};
                            pos = pos + 1'b1;
                            result.chars[pos[esp_pkg::POS_W-1:0]] = {5'b00110, b[5:3]};
                            pos = pos + 1'b1;
                            result.chars[pos[esp_pkg::POS_W-1:0]] = {5'b00110, b[2:0]};
                            pos = pos + 1'b1;
                        end
                        if (item.is_final)
                        begin
                            result.ends = 1'b1;
                            state_next = '0;
                            if (quote_enable)
                            begin
                                result.chars[pos[esp_pkg::POS_W-1:0]] = esp_pkg::CH_QUOTE;
                                pos = pos + 1'b1;
                            end
                        end
                        else if (width_new >= limit)
                        begin
                            trunc = 1'b1;
                            result.ends = 1'b1;
                            state_next.dropping = 1'b1;
                        end
                    end
                    // Closing quote and the truncation mark.
                    if (trunc)
                    begin
                        if (quote_enable)
                        begin
                            result.chars[pos[esp_pkg::POS_W-1:0]] = esp_pkg::CH_QUOTE;
                            pos = pos + 1'b1;
                        end
                        result.chars[pos[esp_pkg::POS_W-1:0]] = esp_pkg::CH_LBRACK;
                        pos = pos + 1'b1;
                        result.chars[pos[esp_pkg::POS_W-1:0]] = esp_pkg::CH_DOT;
                        pos = pos + 1'b1;
                        result.chars[pos[esp_pkg::POS_W-1:0]] = esp_pkg::CH_DOT;
                        pos = pos + 1'b1;
                        result.chars[pos[esp_pkg::POS_W-1:0]] = esp_pkg::CH_DOT;
                        pos = pos + 1'b1;
                        result.chars[pos[esp_pkg::POS_W-1:0]] = esp_pkg::CH_RBRACK;
                        pos = pos + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
        result.count = pos;
    end

endmodule

>>> rtl/escaped_string_printer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_string_printer_top: escaped string printer
// Renders strings byte by byte as printable text with octal escapes,
// optional quotes and truncation at a configurable width limit.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload        Direction
//  in        in_valid / in_stall   in_data        into block, one item
//  out       out_valid / out_stall out_data       out of block, one character
//  cfg       cfg_we                cfg_index/data into block, register write
//
// An accepted item is held in the input register, is rendered in a single
// pass into the character buffer and leaves at one character per cycle
// while out_stall is low, so an item of n characters takes n transfers
// (four for an escape, up to eight with quotes and truncation mark);
// the output channel sets the rate. Items that yield nothing put no
// character out. Reset clears the string state, both registers to their
// defaults and all valid flags. A stall on the output holds the current
// character and backs up into in_stall once the input register is full.
//
module escaped_string_printer_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [esp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [esp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  esp_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output esp_pkg::out_item_t               out_data
);

    logic [esp_pkg::MAX_WIDTH_W-1:0] max_width_reg;
    logic                            quote_enable_reg;
    logic                            in_full_reg;
    logic                            in_full_next;
    esp_pkg::in_item_t               in_item_reg;
    esp_pkg::str_state_t             state_reg;
    esp_pkg::str_state_t             state_next;
    esp_pkg::render_t                render;
    logic [esp_pkg::CHARS_MAX-1:0][7:0] chars_reg;
    logic [esp_pkg::COUNT_W-1:0]     count_reg;
    logic [esp_pkg::COUNT_W-1:0]     idx_reg;
    logic                            ends_reg;
    logic                            buf_valid_reg;
    logic                            in_accept;
    logic                            out_done;
    logic                            is_last;
    logic                            buf_free;
    logic                            move;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg    <= esp_pkg::MAX_WIDTH_RESET;
            quote_enable_reg <= esp_pkg::QUOTE_ENABLE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == esp_pkg::REG_MAX_WIDTH)
            begin
                max_width_reg <= cfg_data;
            end
            else if (cfg_index == esp_pkg::REG_QUOTE_ENABLE)
            begin
                quote_enable_reg <= cfg_data[0];
            end
        end
    end

    // Handshake: the input register moves on when the buffer is empty or
    // its last character is being transferred.
    assign is_last   = (idx_reg == count_reg - 1'b1);
    assign out_done  = out_valid && !out_stall;
    assign buf_free  = !buf_valid_reg || (out_done && is_last);
    assign move      = in_full_reg && buf_free;
    assign in_stall  = in_full_reg && !buf_free;
    assign in_accept = in_valid && !in_stall;

    assign in_full_next = in_accept ? 1'b1 : (move ? 1'b0 : in_full_reg);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_data;
        end
    end

    esp_render u_render
    (
        .state        (state_reg),
        .item         (in_item_reg),
        .max_width    (max_width_reg),
        .quote_enable (quote_enable_reg),
        .result       (render),
        .state_next   (state_next)
    );

    // String state and buffer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (move)
        begin
            state_reg     <= state_next;
            buf_valid_reg <= (render.count != '0);
            idx_reg       <= '0;
        end
        else if (out_done)
        begin
            if (is_last)
            begin
                buf_valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Character buffer payload.
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            chars_reg <= render.chars;
            count_reg <= render.count;
            ends_reg  <= render.ends;
        end
    end

    // Output payload.
    assign out_valid         = buf_valid_reg;
    assign out_data.out_char = chars_reg[idx_reg[esp_pkg::POS_W-1:0]];
    assign out_data.run_last = is_last;
    assign out_data.text_end = is_last && ends_reg;

    // Checks.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg |-> (idx_reg < count_reg))
        else $error("Buffer index beyond character count.");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.text_end) |-> out_data.run_last)
        else $error("Text end raised before the last character of an item.");

    a_drop_started: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.dropping |-> state_reg.started)
        else $error("Dropping state outside an open string.");

    a_width_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.used_width != '0) |-> state_reg.started)
        else $error("Width count held outside an open string.");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the escaped string printer
// A short table of directed strings, then phases of random strings under
// several register settings, with random idling on both channels. Every
// rendered character is checked against an in-bench model of the printer or a typed-in rendering.
// ----------------------------------------------------------------------------
module tb_top;
    import esp_pkg::*;

    // Latency allowance after the last expected character before a write.
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 16;
    localparam int IDLE_PCT      = 19;
    localparam int RANDOM_ITEMS  = 20;
    localparam int NUM_PHASES    = 7;
    localparam logic [7:0] CH_ZERO = 8'h30;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_data;

    escaped_string_printer_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Directed table row: either a register write or an input item, with an
    // optional typed-in rendering.
    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        in_item_t               item;
        bit                     typed;
        string                  text;
        bit                     text_ends;
    } dir_row_t;

    dir_row_t directed_rows[$];

    // Model copy of the registers and of the per-string state.
    logic [MAX_WIDTH_W-1:0] cfg_max_width;
    logic                   cfg_quote;
    logic [USED_W-1:0]      str_used;
    logic                   str_open;
    logic                   str_dropping;

    // Characters the model renders for the item in hand.
    logic [7:0] pred_chars[$];
    bit         pred_ends;

    // Characters still to arrive, oldest first.
    out_item_t pending_chars[$];

    int  mismatch_count;
    int  hold_request;
    bit  calm_mode;

    // ------------------------------------------------------------------------
    // Model of the printer
    // ------------------------------------------------------------------------
    function automatic void emit_char(input logic [7:0] c);
        if (pred_chars.size() < CHARS_MAX)
            pred_chars.push_back(c);
    endfunction

    function automatic void emit_quote();
        if (cfg_quote)
            emit_char(CH_QUOTE);
    endfunction

    function automatic void clear_str();
        str_used     = '0;
        str_open     = 1'b0;
        str_dropping = 1'b0;
    endfunction

    function automatic void add_used(input int n);
        logic [USED_W:0] sum;
        sum = {1'b0, str_used} + (USED_W+1)'(n);
        str_used = sum[USED_W] ? {USED_W{1'b1}} : sum[USED_W-1:0];
    endfunction

    // Closing quote and truncation mark; the rest of the string is dropped.
    function automatic void emit_trunc(input logic last_byte);
        emit_quote();
        emit_char(CH_LBRACK);
        emit_char(CH_DOT);
        emit_char(CH_DOT);
        emit_char(CH_DOT);
        emit_char(CH_RBRACK);
        if (last_byte)
            clear_str();
        else
            str_dropping = 1'b1;
    endfunction

    function automatic void predict_render(input in_item_t it);
        logic [7:0] b;
        logic       plain;
        b = it.data_byte;
        plain = (b >= 8'h20 && b <= 8'h7E) || (b >= 8'h09 && b <= 8'h0D);
        pred_chars.delete();
        pred_ends = 1'b0;
        if (it.mode == MODE_RSVD)
            return;
        if (it.mode == MODE_EMPTY)
        begin
            clear_str();
            emit_quote();
            emit_quote();
            pred_ends = 1'b1;
        end
        else if (it.mode == MODE_NULL)
        begin
            clear_str();
            emit_char(CH_LPAREN);
            emit_char(CH_N);
            emit_char(CH_U);
            emit_char(CH_L);
            emit_char(CH_L);
            emit_char(CH_RPAREN);
            pred_ends = 1'b1;
        end
        else if (str_dropping)
        begin
            if (it.is_final)
                clear_str();
        end
        else
        begin
            if (!str_open)
            begin
                str_open = 1'b1;
                emit_quote();
            end
            if (str_used >= cfg_max_width)
            begin
                // Limit reached before this byte: it is not rendered.
                emit_trunc(it.is_final);
                pred_ends = 1'b1;
            end
            else
            begin
                if (plain)
                begin
                    add_used(1);
                    emit_char(b);
                end
                else
                begin
                    // The escape still counts when it no longer fits.
                    add_used(3);
                    if (str_used < cfg_max_width)
                    begin
                        emit_char(CH_BSLASH);
                        emit_char(CH_ZERO + {6'd0, b[7:6]});
                        emit_char(CH_ZERO + {5'd0, b[5:3]});
                        emit_char(CH_ZERO + {5'd0, b[2:0]});
                    end
                end
                if (it.is_final)
                begin
                    emit_quote();
                    clear_str();
                    pred_ends = 1'b1;
                end
                else if (str_used >= cfg_max_width)
                begin
                    emit_trunc(1'b0);
                    pred_ends = 1'b1;
                end
            end
        end
    endfunction

    // Turns the rendered characters into expected output transfers.
    function automatic void expect_chars();
        out_item_t r;
        for (int k = 0; k < pred_chars.size(); k++)
        begin
            r.out_char = pred_chars[k];
            r.run_last = (k == pred_chars.size() - 1);
            r.text_end = r.run_last && pred_ends;
            pending_chars.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic void row_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.item    = '0;
        row.typed   = 1'b0;
        row.text    = "";
        row.text_ends = 1'b0;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_typed(input logic [MODE_W-1:0] mode, input logic [7:0] b,
                                      input logic fin, input bit typed, input string text,
                                      input bit text_ends);
        dir_row_t row;
        row.is_cfg         = 1'b0;
        row.reg_idx        = '0;
        row.reg_val        = '0;
        row.item.mode      = mode;
        row.item.data_byte = b;
        row.item.is_final  = fin;
        row.typed          = typed;
        row.text           = text;
        row.text_ends      = text_ends;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_item(input logic [MODE_W-1:0] mode, input logic [7:0] b,
                                     input logic fin);
        row_typed(mode, b, fin, 1'b0, "", 1'b0);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and time limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: checks each transfer and stalls at random
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int        hold_left;
        out_item_t want;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected character %h with no expectation", out_data.out_char);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (out_data.out_char !== want.out_char)
                    begin
                        $error("out_char: expected %h, got %h", want.out_char,
                               out_data.out_char);
                        mismatch_count++;
                    end
                    if (out_data.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %b, got %b", want.run_last,
                               out_data.run_last);
                        mismatch_count++;
                    end
                    if (out_data.text_end !== want.text_end)
                    begin
                        $error("text_end: expected %b, got %b", want.text_end,
                               out_data.text_end);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (calm_mode)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one item, records its expected characters on transfer, then
    // idles at random.
    task automatic push_item(input in_item_t it, input bit typed, input string text,
                             input bit text_ends);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_render(it);
        if (typed)
        begin
            pred_chars.delete();
            for (int k = 0; k < text.len(); k++)
                pred_chars.push_back(text[k]);
            pred_ends = text_ends;
        end
        expect_chars();
        if (!calm_mode)
        begin
            // Each idle cycle is drawn on its own.
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Stops offering and waits until every expected character has come.
    task automatic wait_idle(input int extra);
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_WIDTH)
            cfg_max_width = val;
        else if (idx == REG_QUOTE_ENABLE)
            cfg_quote = val[0];
        @(posedge clk);
    endtask

    function automatic logic [7:0] random_byte();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 8'($urandom_range(8'h20, 8'h7E));
        else if (r < 62)
            return 8'($urandom_range(8'h09, 8'h0D));
        return 8'($urandom_range(0, 255));
    endfunction

    // One random string, mostly well formed, sometimes broken by noise or
    // left without its final byte. Returns the number of items that count.
    task automatic send_random_string(output int sent);
        in_item_t it;
        int       len;
        bit       unclosed;
        sent = 0;
        len = ($urandom_range(99) < 10) ? 0 :
              ($urandom_range(99) < 10) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        unclosed = ($urandom_range(99) < 5);
        if (len == 0)
        begin
            it.mode      = MODE_EMPTY;
            it.data_byte = 8'($urandom());
            it.is_final  = 1'($urandom());
            push_item(it, 1'b0, "", 1'b0);
            sent++;
        end
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 6)
            begin
                it.mode      = MODE_W'($urandom_range(1, 3));
                it.data_byte = 8'($urandom());
                it.is_final  = 1'($urandom());
                push_item(it, 1'b0, "", 1'b0);
                if (it.mode != MODE_RSVD)
                    sent++;
            end
            it.mode      = MODE_DATA;
            it.data_byte = random_byte();
            it.is_final  = (i == len - 1) && !unclosed;
            push_item(it, 1'b0, "", 1'b0);
            sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int                     sent;
        int                     phase_items;
        logic [CFG_DATA_W-1:0]  width_val;
        logic [CFG_DATA_W-1:0]  quote_val;

        mismatch_count = 0;
        hold_request   = 0;
        calm_mode      = 1'b0;
        cfg_max_width  = MAX_WIDTH_RESET;
        cfg_quote      = QUOTE_ENABLE_RESET;
        clear_str();

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings at the reset settings, then at tiny limits.
        row_typed(MODE_EMPTY, 8'h00, 1'b0, 1'b1, "\"\"", 1'b1);
        row_typed(MODE_NULL, 8'hA5, 1'b1, 1'b1, "(null)", 1'b1);
        row_typed(MODE_RSVD, 8'hFF, 1'b1, 1'b1, "", 1'b0);
        row_typed(MODE_DATA, 8'h41, 1'b1, 1'b1, "\"A\"", 1'b1);
        row_typed(MODE_DATA, 8'h00, 1'b1, 1'b1, "\"\\000\"", 1'b1);
        row_typed(MODE_DATA, 8'hFF, 1'b1, 1'b1, "\"\\377\"", 1'b1);
        row_item(MODE_DATA, 8'h09, 1'b0);
        row_item(MODE_DATA, 8'h0D, 1'b0);
        row_item(MODE_DATA, 8'h7E, 1'b0);
        row_item(MODE_DATA, 8'h7F, 1'b0);
        row_item(MODE_DATA, 8'h1F, 1'b0);
        row_item(MODE_DATA, 8'h20, 1'b1);
        // A null string abandons the open one without closing it.
        row_item(MODE_DATA, 8'h78, 1'b0);
        row_typed(MODE_NULL, 8'h00, 1'b0, 1'b1, "(null)", 1'b1);
        // Suppressed escape, truncation and dropped bytes.
        row_cfg(REG_MAX_WIDTH, CFG_DATA_W'(5));
        row_item(MODE_DATA, 8'h80, 1'b0);
        row_item(MODE_DATA, 8'h80, 1'b0);
        row_item(MODE_DATA, 8'h7A, 1'b0);
        row_item(MODE_DATA, 8'h7A, 1'b1);
        // Limit already reached when the first byte arrives.
        row_cfg(REG_MAX_WIDTH, CFG_DATA_W'(0));
        row_typed(MODE_DATA, 8'h61, 1'b1, 1'b1, "\"\"[...]", 1'b1);
        row_cfg(REG_QUOTE_ENABLE, CFG_DATA_W'(0));
        row_typed(MODE_DATA, 8'h61, 1'b0, 1'b1, "[...]", 1'b1);
        row_typed(MODE_DATA, 8'h62, 1'b1, 1'b1, "", 1'b0);
        row_typed(MODE_EMPTY, 8'h00, 1'b1, 1'b1, "", 1'b0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                wait_idle(SETTLE_CYCLES);
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                push_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].text, directed_rows[i].text_ends);
        end

        // Random phases, each under its own register settings.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle(SETTLE_CYCLES);
            case (p)
                0:       width_val = CFG_DATA_W'(40);
                1:       width_val = CFG_DATA_W'(0);
                2:       width_val = {CFG_DATA_W{1'b1}};
                3:       width_val = CFG_DATA_W'(80000);
                4:       width_val = CFG_DATA_W'(7);
                5:       width_val = CFG_DATA_W'(16);
                default: width_val = CFG_DATA_W'($urandom_range(0, 60));
            endcase
            // Upper bits of the quote write are ignored by the block.
            quote_val    = CFG_DATA_W'($urandom());
            quote_val[0] = (p == 0 || p == 3) ? 1'b1 : (p == 2) ? 1'b0 : 1'($urandom());
            write_reg(REG_MAX_WIDTH, width_val);
            write_reg(REG_QUOTE_ENABLE, quote_val);

            calm_mode = (p == 3);
            // Long hold-off on the output while strings keep coming in.
            if (p == 2)
                hold_request = 300;

            phase_items = 0;
            while (phase_items < RANDOM_ITEMS)
            begin
                send_random_string(sent);
                phase_items += sent;
            end
        end
        calm_mode = 1'b0;

        wait_idle(END_CYCLES);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> escaped_string_printer_top.f
rtl/esp_pkg.sv
rtl/esp_render.sv
rtl/escaped_string_printer_top.sv
test/tb_top.sv
